// File: hdl/cpt_pkg.sv
// Shared types and constants of the call profile table.
// Used by cpt_ctrl, cpt_dp and call_profile_table; depends on nothing.
package cpt_pkg;

    localparam int SLOT_INDEX_BITS = 16;
    localparam int SLOT_COUNT      = 1 << SLOT_INDEX_BITS;

    localparam int ADDR_W   = 32;
    localparam int TIME_W   = 64;
    localparam int COUNT_W  = 32;
    localparam int RINDEX_W = 16;
    localparam int OP_W     = 2;

    localparam int IN_DATA_W  = 144;
    localparam int OUT_DATA_W = 168;
    localparam int OUT_USED_W = 1 + 2 * ADDR_W + COUNT_W + TIME_W;

    localparam logic [OP_W-1:0] OP_ENTER = 2'd0;
    localparam logic [OP_W-1:0] OP_EXIT  = 2'd1;
    localparam logic [OP_W-1:0] OP_READ  = 2'd2;

    typedef logic [SLOT_INDEX_BITS-1:0] slot_t;

    typedef struct packed {
        logic [ADDR_W-1:0]  tag;
        logic [ADDR_W-1:0]  caller;
        logic [COUNT_W-1:0] count;
        logic [TIME_W-1:0]  start;
        logic [TIME_W-1:0]  total;
    } row_t;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_EXEC
    } state_t;

    typedef struct packed {
        logic capture;
        logic execute;
        logic load_out;
        logic clear_wr;
    } cmd_t;

    typedef struct packed {
        logic            clear_done;
        logic            out_busy;
        logic [OP_W-1:0] op;
    } stat_t;

endpackage

// File: hdl/cpt_ctrl.sv
// Controller of the call profile table: clearing pass, capture and execute steps.
// Depends on cpt_pkg; drives the cpt_dp datapath through cmd_t and reads stat_t.
module cpt_ctrl
    import cpt_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  s_tvalid,
    output logic  s_tready,
    input  stat_t stat,
    output cmd_t  cmd
);

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        case (state_reg)
            ST_CLEAR:
            begin
                cmd.clear_wr = 1'b1;
                if (stat.clear_done)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                s_tready    = 1'b1;
                cmd.capture = s_tvalid;
                if (s_tvalid)
                begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                if (stat.op == OP_READ)
                begin
                    if (!stat.out_busy)
                    begin
                        cmd.load_out = 1'b1;
                        state_next   = ST_IDLE;
                    end
                end
                else
                begin
                    cmd.execute = (stat.op == OP_ENTER) || (stat.op == OP_EXIT);
                    state_next  = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_CLEAR;
            end
        endcase
    end

    a_capture_to_exec: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.capture |=> (state_reg == ST_EXEC))
        else $error("capture not followed by execute");

    a_load_when_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_out |-> !stat.out_busy)
        else $error("result loaded over an untaken beat");

    a_write_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        !(cmd.execute && (cmd.clear_wr || cmd.capture)))
        else $error("update write overlaps clear or capture");

    a_update_one_cycle: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_EXEC && stat.op != OP_READ) |=> (state_reg == ST_IDLE))
        else $error("update step did not return to idle");

endmodule

// File: hdl/cpt_dp.sv
// Datapath of the call profile table: slot memory, input and output registers.
// Depends on cpt_pkg; steered by cpt_ctrl through cmd_t, reports stat_t.
module cpt_dp
    import cpt_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  cmd_t                  cmd,
    output stat_t                 stat,
    input  logic [IN_DATA_W-1:0]  s_tdata,
    input  logic [OP_W-1:0]       s_tuser,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [OUT_DATA_W-1:0] m_tdata
);

    row_t mem [SLOT_COUNT];

    logic [ADDR_W-1:0]   in_fn;
    logic [ADDR_W-1:0]   in_cl;
    logic [TIME_W-1:0]   in_ts;
    logic [RINDEX_W-1:0] in_ri;
    logic [15:0]         fold;
    slot_t               rd_addr;

    logic [OP_W-1:0]   op_reg;
    logic [ADDR_W-1:0] fn_reg;
    logic [ADDR_W-1:0] cl_reg;
    logic [TIME_W-1:0] ts_reg;
    slot_t             addr_reg;
    row_t              rd_row_reg;
    slot_t             clr_cnt_reg;
    logic              m_tvalid_reg;
    logic [OUT_USED_W-1:0] m_data_reg;

    logic  match;
    row_t  upd_row;
    row_t  wr_row;
    slot_t wr_addr;
    logic  wr_en;

    assign in_fn   = s_tdata[31:0];
    assign in_cl   = s_tdata[63:32];
    assign in_ts   = s_tdata[127:64];
    assign in_ri   = s_tdata[143:128];
    assign fold    = in_fn[31:16] | in_fn[15:0] | in_cl[31:16] | in_cl[15:0];
    assign rd_addr = (s_tuser == OP_READ) ? in_ri[SLOT_INDEX_BITS-1:0]
                                          : fold[SLOT_INDEX_BITS-1:0];

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            op_reg     <= s_tuser;
            fn_reg     <= in_fn;
            cl_reg     <= in_cl;
            ts_reg     <= in_ts;
            addr_reg   <= rd_addr;
            rd_row_reg <= mem[rd_addr];
        end
    end

    always_comb
    begin
        match   = (rd_row_reg.tag == fn_reg);
        upd_row = rd_row_reg;
        if (op_reg == OP_ENTER)
        begin
            upd_row.tag    = fn_reg;
            upd_row.caller = match ? rd_row_reg.caller : cl_reg;
            upd_row.count  = (match ? rd_row_reg.count : '0) + COUNT_W'(1);
            upd_row.total  = match ? rd_row_reg.total : '0;
            upd_row.start  = ts_reg;
        end
        else
        begin
            upd_row.total = rd_row_reg.total + (ts_reg - rd_row_reg.start);
        end
    end

    assign wr_en   = cmd.clear_wr | cmd.execute;
    assign wr_addr = cmd.clear_wr ? clr_cnt_reg : addr_reg;
    assign wr_row  = cmd.clear_wr ? '0 : upd_row;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_row;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_cnt_reg <= '0;
        end
        else if (cmd.clear_wr)
        begin
            clr_cnt_reg <= clr_cnt_reg + slot_t'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tvalid_reg <= 1'b0;
        end
        else if (cmd.load_out)
        begin
            m_tvalid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_out)
        begin
            m_data_reg <= {rd_row_reg.total, rd_row_reg.count, rd_row_reg.caller,
                           rd_row_reg.tag, (rd_row_reg.tag != '0)};
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {{(OUT_DATA_W - OUT_USED_W){1'b0}}, m_data_reg};

    assign stat.clear_done = (clr_cnt_reg == {SLOT_INDEX_BITS{1'b1}});
    assign stat.out_busy   = m_tvalid_reg & ~m_tready;
    assign stat.op         = op_reg;

endmodule

// File: hdl/call_profile_table.sv
// Top level of the call profile table: stream ports, controller and datapath.
// Depends on cpt_pkg, cpt_ctrl and cpt_dp.
//
//  group | direction | tdata (low bit up)                            | tuser
//  s_*   | in        | function, caller, timestamp, read_index       | operation
//  m_*   | out       | slot_used, function, caller, count, total     | -
//
// Each accepted beat is a memory read on capture, then a write-back or a result load.
// After reset a clearing pass writes each of the 2^SLOT_INDEX_BITS (65536) slots once,
// with s_tready low.
// A read beat holds in its execute step while the output register keeps an untaken beat.
// Enter, exit and unused operation beats produce no output beat.
module call_profile_table
    import cpt_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    // function_address, caller_address, timestamp, read_index
    input  logic [IN_DATA_W-1:0]  s_tdata,
    // operation
    input  logic [OP_W-1:0]       s_tuser,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // slot_used, slot_function, slot_caller, call_count, total_time, zero fill
    output logic [OUT_DATA_W-1:0] m_tdata
);

    cmd_t  cmd;
    stat_t stat;

    cpt_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    cpt_dp u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd),
        .stat     (stat),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

endmodule
